// ===== design/signal_state_flicker_filter_core_defines.svh =====
// Assertion macros for the signal state flicker filter.
// Included by the top level; no other dependencies.
`ifndef SIGNAL_STATE_FLICKER_FILTER_CORE_DEFINES_SVH
`define SIGNAL_STATE_FLICKER_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sff_pkg.sv =====
// Shared types and constants of the signal state flicker filter.
// No dependencies.
`timescale 1ns / 1ps

package sff_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_W           = 16;
  localparam int OUT_W           = 16;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  // State codes
  localparam logic [2:0] ST_NONE   = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_RED    = 3'd2;
  localparam logic [2:0] ST_AMBER  = 3'd3;
  localparam logic [2:0] ST_GREEN  = 3'd4;
  localparam logic [2:0] ST_UP     = 3'd5;
  localparam logic [2:0] ST_DOWN   = 3'd6;
  localparam logic [2:0] ST_UNUSED = 3'd7;

  localparam logic [7:0] ALIGN_JOB   = 8'd18;
  localparam int         COUNT_RESET = 1000;
  localparam int         MS_PER_SEC  = 1000;

  // Register indexes
  localparam logic [1:0] REG_FLICKER  = 2'd0;
  localparam logic [1:0] REG_RED_TOL  = 2'd1;
  localparam logic [1:0] REG_MAX_SECS = 2'd2;

  localparam logic [CFG_W-1:0] FLICKER_RST  = 16'd5;
  localparam logic [CFG_W-1:0] RED_TOL_RST  = 16'd3;
  localparam logic [CFG_W-1:0] MAX_SECS_RST = 16'd60;

  typedef struct packed {
    logic [CFG_W-1:0] flicker;
    logic [CFG_W-1:0] red_tol;
    logic [31:0]      align_limit; // (max seconds + 1) * 1000 ms
  } sff_cfg_t;

  typedef struct packed {
    logic [2:0]       state;
    logic [OUT_W-1:0] red_run;
    logic [OUT_W-1:0] red_absent;
  } sff_result_t;

endpackage

// ===== design/sff_regs.sv =====
// Configuration registers with APB-style access.
// Depends on sff_pkg.
`timescale 1ns / 1ps

module sff_regs
  import sff_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output sff_cfg_t          cfg
);

  logic [CFG_W-1:0] flicker;
  logic [CFG_W-1:0] red_tol;
  logic [CFG_W-1:0] max_secs;
  logic [31:0]      align_limit;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic [31:0]      limit_next;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // elapsed / 1000 > max  <=>  elapsed >= (max + 1) * 1000
  assign limit_next = 32'(({1'b0, pwdata[CFG_W-1:0]} + 17'd1) * 32'(MS_PER_SEC));

  always_ff @(posedge clk) begin
    if (rst) begin
      flicker     <= FLICKER_RST;
      red_tol     <= RED_TOL_RST;
      max_secs    <= MAX_SECS_RST;
      align_limit <= 32'((32'(MAX_SECS_RST) + 32'd1) * 32'(MS_PER_SEC));
    end else if (wr_en) begin
      case (reg_idx)
        REG_FLICKER:  flicker <= pwdata[CFG_W-1:0];
        REG_RED_TOL:  red_tol <= pwdata[CFG_W-1:0];
        REG_MAX_SECS: begin
          max_secs    <= pwdata[CFG_W-1:0];
          align_limit <= limit_next;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLICKER:  prdata = DATA_W'(flicker);
      REG_RED_TOL:  prdata = DATA_W'(red_tol);
      REG_MAX_SECS: prdata = DATA_W'(max_secs);
      default:      prdata = '0;
    endcase
  end

  assign cfg.flicker     = flicker;
  assign cfg.red_tol     = red_tol;
  assign cfg.align_limit = align_limit;

endmodule

// ===== design/sff_filter.sv =====
// Filter state and per-word update: counters, arrow fill, Red tolerance, alignment force.
// Depends on sff_pkg.
`timescale 1ns / 1ps

module sff_filter
  import sff_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [2:0]  class_in,
  input  logic [7:0]  job_status,
  input  logic [31:0] now_ms,
  input  sff_cfg_t    cfg,
  output sff_result_t result
);

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_INIT = COUNT_WIDTH'(COUNT_RESET);

  logic [COUNT_WIDTH-1:0] since_up, since_down, red_run, red_absent;
  logic [COUNT_WIDTH-1:0] since_up_next, since_down_next, red_run_next, red_absent_next;
  logic [2:0]             prev_state, prev_state_next;
  logic                   align_active, align_active_next;
  logic [31:0]            align_start_ms, align_start_ms_next;

  logic [2:0]       s_in, s_fill, s_out;
  logic [CMP_W-1:0] up_x, down_x, run_x, flick_x, tol_x;
  logic             no_light, align_start;
  logic [31:0]      elapsed;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == '1) ? v : COUNT_WIDTH'(v + 1'b1);
  endfunction

  always_comb begin
    // Fold the unused code to none and amber to Red
    s_in = class_in;
    if (s_in == ST_UNUSED) s_in = ST_NONE;
    if (s_in == ST_AMBER)  s_in = ST_RED;

    since_up_next   = (s_in == ST_UP)   ? '0 : sat_inc(since_up);
    since_down_next = (s_in == ST_DOWN) ? '0 : sat_inc(since_down);
    if (s_in == ST_RED) begin
      red_run_next    = sat_inc(red_run);
      red_absent_next = '0;
    end else begin
      red_run_next    = '0;
      red_absent_next = sat_inc(red_absent);
    end

    up_x    = CMP_W'(since_up_next);
    down_x  = CMP_W'(since_down_next);
    run_x   = CMP_W'(red_run_next);
    flick_x = CMP_W'(cfg.flicker);
    tol_x   = CMP_W'(cfg.red_tol);

    s_fill = s_in;
    if (s_in == ST_NONE || s_in == ST_EMPTY) begin
      if (up_x < down_x && up_x <= flick_x) s_fill = ST_UP;
      else if (down_x <= flick_x)          s_fill = ST_DOWN;
    end else if (s_in == ST_RED) begin
      if (run_x <= tol_x) s_fill = prev_state;
    end
    prev_state_next = s_fill;

    no_light            = (s_fill == ST_NONE) || (s_fill == ST_EMPTY);
    align_start         = 1'b0;
    align_active_next   = 1'b0;
    align_start_ms_next = align_start_ms;
    elapsed             = '0;
    s_out               = s_fill;
    if (job_status == ALIGN_JOB) begin
      align_start = !align_active && !no_light && s_fill != ST_UNUSED;
      align_active_next   = align_active || align_start;
      align_start_ms_next = align_start ? now_ms : align_start_ms;
      elapsed = now_ms - align_start_ms_next;
      if (align_active_next && !no_light && elapsed >= cfg.align_limit) s_out = ST_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_up     <= CNT_INIT;
      since_down   <= CNT_INIT;
      red_run      <= CNT_INIT;
      red_absent   <= CNT_INIT;
      prev_state   <= ST_NONE;
      align_active <= 1'b0;
    end else if (step) begin
      since_up     <= since_up_next;
      since_down   <= since_down_next;
      red_run      <= red_run_next;
      red_absent   <= red_absent_next;
      prev_state   <= prev_state_next;
      align_active <= align_active_next;
    end
  end

  // Start time is only read once the alignment flag is set
  always_ff @(posedge clk) begin
    if (step) align_start_ms <= align_start_ms_next;
  end

  assign result.state      = s_out;
  assign result.red_run    = OUT_W'(red_run_next);
  assign result.red_absent = OUT_W'(red_absent_next);

endmodule

// ===== design/signal_state_flicker_filter_core.sv =====
// Top level of the signal state flicker filter: input register, filter, result register.
// Depends on sff_pkg, sff_regs, sff_filter and signal_state_flicker_filter_core_defines.svh.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_ready   class_in, job_status, now_ms
//   result    out        out_valid/out_ready state_out, red_run_out, red_absent_out
//   config    in         psel/penable/pready paddr, pwrite, pwdata, prdata
//
// Each word passes through the input register and then the result register, with the
// combinational filter update between the two; one word per cycle is sustained while
// the result side keeps out_ready high.
// Reset (rst, synchronous) empties both registers, loads the counters with 1000
// and restores the register defaults (5, 3, 60 seconds).
// A stalled result holds the result register; the input register still takes a
// word while it is empty, then backs up to in_ready.
`timescale 1ns / 1ps
`include "signal_state_flicker_filter_core_defines.svh"

module signal_state_flicker_filter_core
  import sff_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        class_in,
  input  logic [7:0]        job_status,
  input  logic [31:0]       now_ms,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        state_out,
  output logic [OUT_W-1:0]  red_run_out,
  output logic [OUT_W-1:0]  red_absent_out,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  sff_cfg_t    cfg;
  sff_result_t result;

  // Input register
  logic        pipe_valid;
  logic [2:0]  pipe_class;
  logic [7:0]  pipe_job;
  logic [31:0] pipe_now;

  logic        advance;

  assign pready = 1'b1;

  // Move a word into the result register when it is empty or being drained
  assign advance  = pipe_valid && (!out_valid || out_ready);
  assign in_ready = !pipe_valid || advance;

  sff_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Filter state advances only when a word moves into the result register
  sff_filter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .class_in   (pipe_class),
    .job_status (pipe_job),
    .now_ms     (pipe_now),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_ready) begin
      pipe_valid <= in_valid;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pipe_class <= class_in;
      pipe_job   <= job_status;
      pipe_now   <= now_ms;
    end
  end

  // Result register: refill or drop depending on the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out      <= result.state;
      red_run_out    <= result.red_run;
      red_absent_out <= result.red_absent;
    end
  end

  // Both stages full and the result stalled: no room for another word
  `SFF_ASSERT_NOW(a_full_backpressure, clk, rst, pipe_valid && out_valid && !out_ready, !in_ready, "input accepted while pipeline is full")
  // A word that advances shows up as a valid result next cycle
  `SFF_ASSERT_NEXT(a_advance_fills, clk, rst, advance, out_valid, "advanced word lost")
  // Amber is always folded to Red, unused code never leaves
  `SFF_ASSERT_NOW(a_state_code, clk, rst, out_valid, state_out != ST_AMBER && state_out != ST_UNUSED, "illegal filtered state")
  // Red run and Red-absent counters never both count
  `SFF_ASSERT_NOW(a_red_counters, clk, rst, out_valid, red_run_out == '0 || red_absent_out == '0, "Red counters both nonzero")

endmodule

// ===== bench/signal_state_flicker_filter_checker.sv =====
// Result checker for the signal state flicker filter: follows the register port and
// both word channels, predicts every result word and compares it. Depends on sff_pkg.
`timescale 1ns / 1ps

module signal_state_flicker_filter_checker
  import sff_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        class_in,
  input  logic [7:0]        job_status,
  input  logic [31:0]       now_ms,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        state_out,
  input  logic [OUT_W-1:0]  red_run_out,
  input  logic [OUT_W-1:0]  red_absent_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_TOP  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_INIT = COUNT_WIDTH'(COUNT_RESET);

  logic [CFG_W-1:0]       flicker_cfg;
  logic [CFG_W-1:0]       red_tol_cfg;
  logic [CFG_W-1:0]       max_secs_cfg;
  logic [COUNT_WIDTH-1:0] since_up;
  logic [COUNT_WIDTH-1:0] since_down;
  logic [COUNT_WIDTH-1:0] red_run;
  logic [COUNT_WIDTH-1:0] red_absent;
  logic [2:0]             last_state;
  logic                   align_on;
  logic [31:0]            align_t0;
  sff_result_t            filtered_q[$];

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_TOP) ? COUNT_TOP : v + 1'b1;
  endfunction

  // Advance the filter state by one frame and return the word it must produce.
  function automatic sff_result_t filter_frame(input logic [2:0] cls, input logic [7:0] job,
                                               input logic [31:0] now);
    logic [2:0]  s;
    logic [31:0] elapsed;
    sff_result_t r;
    s = cls;
    if (s == ST_UNUSED) s = ST_NONE;
    if (s == ST_AMBER) s = ST_RED;
    since_up   = bump(since_up);
    since_down = bump(since_down);
    if (s == ST_UP) since_up = '0;
    else if (s == ST_DOWN) since_down = '0;
    if (s == ST_RED) begin
      red_run    = bump(red_run);
      red_absent = '0;
    end else begin
      red_run    = '0;
      red_absent = bump(red_absent);
    end
    // fill dropouts with the more recent arrow, mask the head of a Red run
    if (s == ST_NONE || s == ST_EMPTY) begin
      if (since_up < since_down && since_up <= flicker_cfg) s = ST_UP;
      else if (since_down <= flicker_cfg) s = ST_DOWN;
    end else if (s == ST_RED && red_run <= red_tol_cfg) begin
      s = last_state;
    end
    last_state = s;
    if (job == ALIGN_JOB) begin
      if (!align_on && s >= ST_RED && s <= ST_DOWN) begin
        align_on = 1'b1;
        align_t0 = now;
      end
      if (align_on && s != ST_NONE && s != ST_EMPTY) begin
        elapsed = now - align_t0;
        if (elapsed / MS_PER_SEC > max_secs_cfg) s = ST_RED;
      end
    end else begin
      align_on = 1'b0;
    end
    r.state      = s;
    r.red_run    = red_run[OUT_W-1:0];
    r.red_absent = red_absent[OUT_W-1:0];
    return r;
  endfunction

  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    sff_result_t want;
    logic [CFG_W-1:0] reg_val;
    if (rst) begin
      flicker_cfg  = FLICKER_RST;
      red_tol_cfg  = RED_TOL_RST;
      max_secs_cfg = MAX_SECS_RST;
      since_up     = COUNT_INIT;
      since_down   = COUNT_INIT;
      red_run      = COUNT_INIT;
      red_absent   = COUNT_INIT;
      last_state   = ST_NONE;
      align_on     = 1'b0;
      align_t0     = '0;
      filtered_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          flag($sformatf("result word %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = filtered_q.pop_front();
          if (state_out !== want.state || red_run_out !== want.red_run ||
              red_absent_out !== want.red_absent)
            flag($sformatf({"result word %0d expected state %0d run %0d absent %0d,",
                            " got state %0d run %0d absent %0d"}, results_seen,
                           want.state, want.red_run, want.red_absent,
                           state_out, red_run_out, red_absent_out));
        end
      end
      if (in_valid && in_ready) filtered_q.push_back(filter_frame(class_in, job_status, now_ms));
      if (psel && penable && pready) begin
        case (paddr[3:2])
          REG_FLICKER:  reg_val = flicker_cfg;
          REG_RED_TOL:  reg_val = red_tol_cfg;
          REG_MAX_SECS: reg_val = max_secs_cfg;
          default:      reg_val = '0;
        endcase
        if (pwrite) begin
          case (paddr[3:2])
            REG_FLICKER:  flicker_cfg  = pwdata[CFG_W-1:0];
            REG_RED_TOL:  red_tol_cfg  = pwdata[CFG_W-1:0];
            REG_MAX_SECS: max_secs_cfg = pwdata[CFG_W-1:0];
            default: ;
          endcase
        end else if (prdata !== DATA_W'(reg_val)) begin
          flag($sformatf("register at 0x%0h read 0x%0h, expected 0x%0h",
                         paddr, prdata, reg_val));
        end
      end
    end
    pending <= filtered_q.size();
  end

endmodule

// ===== bench/signal_state_flicker_filter_core_tb.sv =====
// Testbench top for the signal state flicker filter core: clock, reset, stimulus,
// register programming and verdict. Depends on sff_pkg, the core and its checker.
`timescale 1ns / 1ps

module signal_state_flicker_filter_core_tb;
  import sff_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 1150;
  localparam int PHASES       = 7;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        class_in;
  logic [7:0]        job_status;
  logic [31:0]       now_ms;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        state_out;
  logic [OUT_W-1:0]  red_run_out;
  logic [OUT_W-1:0]  red_absent_out;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int results_seen;

  int          words_sent  = 0;
  int          cycle_count = 0;
  int          settings    = 0;
  bit          src_calm    = 1'b0;
  logic [31:0] clock_ms    = '0;

  // Current register values, kept only to shape the stimulus.
  logic [CFG_W-1:0] cur_flicker = FLICKER_RST;
  logic [CFG_W-1:0] cur_tol     = RED_TOL_RST;
  logic [CFG_W-1:0] cur_secs    = MAX_SECS_RST;

  signal_state_flicker_filter_core uut (.*);

  signal_state_flicker_filter_checker checker_i (.*);

  always #2 clk = ~clk;

  // Watchdog: end the run if the block stops moving words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each word, with calm stretches
  // where out_ready stays high so back-to-back words get through.
  initial begin : sink
    int unsigned gap;
    bit          calm;
    int          taken;
    calm  = 1'b0;
    taken = 0;
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // Present one input word after a random gap and hold it until it is taken.
  task automatic send_word(input logic [2:0] cls, input logic [7:0] job,
                           input logic [31:0] now);
    int unsigned gap;
    if (words_sent % 32 == 0) src_calm = ($urandom_range(0, 3) == 0);
    gap = src_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    class_in   <= cls;
    job_status <= job;
    now_ms     <= now;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    words_sent++;
  endtask

  // Drop valid and hold off until every predicted word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write one register, then read it back; psel stays high between transfers.
  task automatic access_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] flick, input logic [CFG_W-1:0] tol,
                              input logic [CFG_W-1:0] secs);
    access_reg(REG_FLICKER, flick);
    access_reg(REG_RED_TOL, tol);
    access_reg(REG_MAX_SECS, secs);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_flicker = flick;
    cur_tol     = tol;
    cur_secs    = secs;
    settings++;
  endtask

  // Mostly small values so the windows get crossed; now and then the full range.
  function automatic logic [CFG_W-1:0] pick(input int unsigned lim);
    return ($urandom_range(0, 4) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, lim));
  endfunction

  function automatic logic [31:0] next_ms(input int unsigned span);
    clock_ms = clock_ms + $urandom_range(0, span);
    return clock_ms;
  endfunction

  function automatic logic [2:0] dropout_code();
    case ($urandom_range(0, 2))
      0:       return ST_NONE;
      1:       return ST_EMPTY;
      default: return ST_UNUSED;
    endcase
  endfunction

  function automatic logic [2:0] clear_code();
    case ($urandom_range(0, 3))
      0:       return ST_GREEN;
      1:       return ST_UP;
      2:       return ST_DOWN;
      default: return ST_EMPTY;
    endcase
  endfunction

  // One random stretch of frames: noise, an arrow with dropouts, a Red run, or an
  // alignment job with advancing time.
  task automatic send_sequence();
    int unsigned choice;
    int unsigned n;
    int unsigned lim;
    int unsigned r;
    logic [7:0]  job;
    logic [2:0]  cls;
    choice = $urandom_range(0, 9);
    job    = ($urandom_range(0, 2) == 0) ? ALIGN_JOB : 8'($urandom_range(0, 255));
    if (choice < 3) begin
      // noise: any code, any job, any time
      n = $urandom_range(1, 6);
      repeat (n)
        send_word(3'($urandom_range(0, 7)),
                  ($urandom_range(0, 3) == 0) ? ALIGN_JOB : 8'($urandom), $urandom);
    end else if (choice < 5) begin
      // arrow followed by dropouts around the flicker window, with rival arrows mixed in
      send_word($urandom_range(0, 1) ? ST_UP : ST_DOWN, job, next_ms(120));
      lim = (cur_flicker < 10) ? cur_flicker + 2 : 12;
      n   = $urandom_range(0, lim);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 7)       cls = dropout_code();
        else if (r == 7) cls = ST_UP;
        else if (r == 8) cls = ST_DOWN;
        else             cls = 3'($urandom_range(0, 7));
        send_word(cls, job, next_ms(120));
      end
    end else if (choice < 7) begin
      // Red run of random length around the tolerance, framed by other states
      send_word(clear_code(), job, next_ms(120));
      lim = (cur_tol < 8) ? cur_tol + 3 : 10;
      n   = $urandom_range(1, lim);
      repeat (n) send_word($urandom_range(0, 1) ? ST_RED : ST_AMBER, job, next_ms(120));
      send_word(clear_code(), job, next_ms(120));
    end else begin
      // alignment job; start near the time wrap now and then
      if ($urandom_range(0, 7) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
      n = $urandom_range(4, 20);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r == 0)      clock_ms = clock_ms + $urandom;
        else if (r == 1) clock_ms = clock_ms + cur_secs * 1000 + $urandom_range(0, 1999);
        else             clock_ms = clock_ms + $urandom_range(0, 1500);
        send_word(3'($urandom_range(0, 7)), ALIGN_JOB, clock_ms);
      end
      if ($urandom_range(0, 1) == 0) send_word(clear_code(), job, next_ms(120));
    end
  endtask

  initial begin : stimulus
    logic [31:0] t0;
    logic [31:0] t1;
    int          phase_end;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    class_in   <= ST_NONE;
    job_status <= '0;
    now_ms     <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frames on the reset settings (flicker 5, tolerance 3, 60 s).
    t0 = 32'hFFFF_F000;
    t1 = 32'h1234_5678;
    send_word(ST_GREEN,  8'h00, 32'h0000_0000);
    send_word(ST_UP,     8'hFF, 32'hFFFF_FFFF);
    send_word(ST_NONE,   8'h00, 32'h0000_0000);  // filled with the up arrow
    send_word(ST_EMPTY,  8'h00, 32'h0000_0000);
    send_word(ST_DOWN,   8'h00, 32'h0000_0000);
    send_word(ST_UNUSED, 8'h00, 32'h0000_0000);  // unused code acts as none
    send_word(ST_AMBER,  8'h00, 32'h0000_0000);  // amber starts a Red run, masked
    send_word(ST_RED,    8'h00, 32'h0000_0000);
    send_word(ST_RED,    8'h00, 32'h0000_0000);
    send_word(ST_RED,    8'h00, 32'h0000_0000);  // run passes the tolerance
    send_word(ST_GREEN,  8'hFF, 32'hFFFF_FFFF);
    send_word(ST_GREEN,  ALIGN_JOB, t0);          // light seen, alignment timer starts
    send_word(ST_GREEN,  ALIGN_JOB, t0 + 60999);  // just under the limit, across the wrap
    send_word(ST_GREEN,  ALIGN_JOB, t0 + 61000);  // first frame forced to Red
    send_word(ST_NONE,   ALIGN_JOB, t0 + 62000);  // none is never forced
    send_word(ST_EMPTY,  ALIGN_JOB, t0 + 63000);
    send_word(ST_AMBER,  8'd17, t0 + 64000);      // other job drops the timer
    send_word(ST_NONE,   ALIGN_JOB, 32'h0);       // none does not start the timer
    send_word(ST_UP,     ALIGN_JOB, t1);
    send_word(ST_DOWN,   ALIGN_JOB, t1 + 61000);
    drain();

    // Random phases, each on its own register setting; the block is idle between them.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       program_regs('0, '0, '0);
        1:       program_regs('1, '1, '1);
        2:       program_regs(16'd1, 16'd2, 16'd1);
        default: program_regs(pick(8), pick(6), pick(4));
      endcase
      phase_end = 20 + (phase + 1) * RANDOM_WORDS / PHASES;
      while (words_sent < phase_end) send_sequence();
      drain();
    end

    repeat (6) @(posedge clk);
    $display("Sent %0d words, checked %0d result words over %0d register settings", words_sent,
             results_seen, settings + 1);
    $display("including all-zero and all-ones windows, arrow fill, Red masking and time wrap");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sff_pkg.sv
design/sff_regs.sv
design/sff_filter.sv
design/signal_state_flicker_filter_core.sv
bench/signal_state_flicker_filter_checker.sv
bench/signal_state_flicker_filter_core_tb.sv
